// ----- hdl/bqcd_pkg.sv -----
`default_nettype none
package bqcd_pkg;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;
  localparam logic [15:0] Q_MIN       = 16'd128;
  localparam logic [2:0]  FT_LAST     = 3'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CUTOFF = 2'd1;
  localparam logic [1:0] ST_TYPE   = 2'd2;

  localparam logic [1:0] FT_LP = 2'd0;
  localparam logic [1:0] FT_HP = 2'd1;
  localparam logic [1:0] FT_BP = 2'd2;
  localparam logic [1:0] FT_BS = 2'd3;

  localparam int ATAN_DEPTH = 40;
  localparam logic [30:0] ATAN_Q30 [ATAN_DEPTH] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127, 31'd63, 31'd31, 31'd15, 31'd7, 31'd3, 31'd1,
    31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0
  };

  typedef struct packed {
    logic [1:0]  stat;
    logic [1:0]  ft;
    logic [15:0] qc;
  } ang_tag_t;

  typedef struct packed {
    logic [1:0]  stat;
    logic [1:0]  ft;
    logic [15:0] qc;
    logic        fold;
  } rot_tag_t;

  typedef struct packed {
    logic [1:0]         stat;
    logic [1:0]         ft;
    logic signed [33:0] c;
  } alp_tag_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [33:0] cordic_gain(input int steps);
    logic [63:0] p;
    logic [63:0] m;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] q;
    p = 64'd1 << 30;
    for (int i = 0; i < steps; i++) begin
      p = p + (p >> (2 * i));
    end
    m = isqrt64(p << 30);
    if (m == 64'd0) m = 64'd1;
    n = (64'd1 << 60) + (m >> 1);
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      if (r >= m) begin
        r    = r - m;
        q[k] = 1'b1;
      end
    end
    return q[33:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bqcd_in_if.sv -----
`default_nettype none
interface bqcd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  filter_type;
  logic [15:0] quality;
  logic [16:0] cutoff;
  modport source(output valid, filter_type, quality, cutoff, input ready);
  modport sink(input valid, filter_type, quality, cutoff, output ready);
endinterface
`default_nettype wire

// ----- hdl/bqcd_out_if.sv -----
`default_nettype none
interface bqcd_out_if #(parameter int COEF_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [COEF_WIDTH-1:0] coef_b0;
  logic signed [COEF_WIDTH-1:0] coef_b1;
  logic signed [COEF_WIDTH-1:0] coef_b2;
  logic signed [COEF_WIDTH-1:0] coef_a1;
  logic signed [COEF_WIDTH-1:0] coef_a2;
  modport source(output valid, status, coef_b0, coef_b1, coef_b2, coef_a1, coef_a2,
                 input ready);
  modport sink(input valid, status, coef_b0, coef_b1, coef_b2, coef_a1, coef_a2,
               output ready);
endinterface
`default_nettype wire

// ----- hdl/bqcd_div.sv -----
`default_nettype none
module bqcd_div #(
  parameter int NW  = 50,
  parameter int DW  = 18,
  parameter int QW  = 32,
  parameter int SPS = 4,
  parameter int TW  = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          vld_out,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  localparam int NS = (QW + SPS - 1) / SPS;

  logic          vld_r [NS];
  logic [DW-1:0] rem_r [NS];
  logic [QW-1:0] low_r [NS];
  logic [QW-1:0] quo_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [TW-1:0] tag_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [QW-1:0] l_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [TW-1:0] t_in;
    logic [DW-1:0] r_out;
    logic [QW-1:0] l_out;
    logic [QW-1:0] q_out;

    if (s == 0) begin : g_first
      assign v_in = vld_in;
      assign r_in = DW'(num >> QW);
      assign l_in = num[QW-1:0];
      assign q_in = '0;
      assign d_in = den;
      assign t_in = tag_in;
    end else begin : g_next
      assign v_in = vld_r[s-1];
      assign r_in = rem_r[s-1];
      assign l_in = low_r[s-1];
      assign q_in = quo_r[s-1];
      assign d_in = den_r[s-1];
      assign t_in = tag_r[s-1];
    end

    always_comb begin
      logic [DW:0] t;
      r_out = r_in;
      l_out = l_in;
      q_out = q_in;
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < QW) begin
          t     = {r_out, l_out[QW-1]};
          l_out = l_out << 1;
          if (t >= {1'b0, d_in}) begin
            r_out = DW'(t - {1'b0, d_in});
            q_out = {q_out[QW-2:0], 1'b1};
          end else begin
            r_out = t[DW-1:0];
            q_out = {q_out[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= r_out;
        low_r[s] <= l_out;
        quo_r[s] <= q_out;
        den_r[s] <= d_in;
        tag_r[s] <= t_in;
      end
    end
  end

  assign vld_out = vld_r[NS-1];
  assign quo     = quo_r[NS-1];
  assign tag_out = tag_r[NS-1];

endmodule
`default_nettype wire

// ----- hdl/biquad_coefficient_designer.sv -----
// Pipeline: range checks, the angle divider (4 quotient bits a stage), the CORDIC
// rotator (one iteration a stage), the alpha divider (4 quotient bits a stage), the
// numerators and a0, and the coefficient dividers (2 quotient bits a stage).
// Throughput: one word per cycle; the input stalls only when the output skid is full.
// Reset: synchronous, active high; clears all valid bits and sets sample_rate to 48000.
`default_nettype none
module biquad_coefficient_designer
  import bqcd_pkg::*;
#(
  parameter int COEF_WIDTH   = 32,
  parameter int CORDIC_STEPS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_rate_we,
  input  logic [17:0]       sample_rate_wdata,
  bqcd_in_if.sink           req,
  bqcd_out_if.source        rsp
);

  localparam int W    = COEF_WIDTH;
  localparam int F    = COEF_WIDTH - 3;
  localparam int CN_W = 34 + F + 1;
  localparam logic signed [33:0] GAIN = $signed(cordic_gain(CORDIC_STEPS));
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  logic [17:0] sample_rate;
  logic        adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= 18'd48000;
    end else if (sample_rate_we) begin
      sample_rate <= sample_rate_wdata;
    end
  end

  // Stage A: range checks, the quality clamp and the angle numerator.
  logic        a_v;
  ang_tag_t    a_tag;
  logic [49:0] a_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (req.cutoff == 17'd0 || {req.cutoff, 1'b0} >= sample_rate) begin
        a_tag.stat <= ST_CUTOFF;
      end else if (req.filter_type > FT_LAST) begin
        a_tag.stat <= ST_TYPE;
      end else begin
        a_tag.stat <= ST_OK;
      end
      a_tag.ft <= req.filter_type[1:0];
      a_tag.qc <= (req.quality < Q_MIN) ? Q_MIN : req.quality;
      a_prod   <= {49'(req.cutoff) * 49'(PI_Q30), 1'b0};
    end
  end

  logic        ad_v;
  logic [31:0] ad_ang;
  ang_tag_t    ad_tag;

  bqcd_div #(.NW(50), .DW(18), .QW(32), .SPS(4), .TW($bits(ang_tag_t))) u_ang_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (a_v),
    .num     (a_prod),
    .den     (sample_rate),
    .tag_in  (a_tag),
    .vld_out (ad_v),
    .quo     (ad_ang),
    .tag_out (ad_tag)
  );

  // CORDIC: entry 0 holds the folded angle, entry i+1 the result of iteration i.
  logic               cv [CORDIC_STEPS+1];
  logic signed [33:0] cx [CORDIC_STEPS+1];
  logic signed [33:0] cy [CORDIC_STEPS+1];
  logic signed [33:0] cz [CORDIC_STEPS+1];
  rot_tag_t           ct [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= ad_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0]      <= GAIN;
      cy[0]      <= '0;
      ct[0].stat <= ad_tag.stat;
      ct[0].ft   <= ad_tag.ft;
      ct[0].qc   <= ad_tag.qc;
      if (ad_ang > HALF_PI_Q30) begin
        cz[0]      <= $signed(34'(PI_Q30) - 34'(ad_ang));
        ct[0].fold <= 1'b1;
      end else begin
        cz[0]      <= $signed(34'(ad_ang));
        ct[0].fold <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (adv) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ct[i+1] <= ct[i];
        if (!cz[i][33]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed({3'b0, ATAN_Q30[i]});
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed({3'b0, ATAN_Q30[i]});
        end
      end
    end
  end

  // Stage C: unfold the cosine and clamp the sine.
  logic               c_v;
  logic [30:0]        c_s;
  logic [15:0]        c_qc;
  alp_tag_t           c_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tag.stat <= ct[CORDIC_STEPS].stat;
      c_tag.ft   <= ct[CORDIC_STEPS].ft;
      c_tag.c    <= ct[CORDIC_STEPS].fold ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
      c_s        <= cy[CORDIC_STEPS][33] ? '0 : cy[CORDIC_STEPS][30:0];
      c_qc       <= ct[CORDIC_STEPS].qc;
    end
  end

  logic        al_v;
  logic [31:0] al_q;
  alp_tag_t    al_tag;

  bqcd_div #(.NW(38), .DW(16), .QW(32), .SPS(4), .TW($bits(alp_tag_t))) u_alpha_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (c_v),
    .num     ({c_s, 7'b0}),
    .den     (c_qc),
    .tag_in  (c_tag),
    .vld_out (al_v),
    .quo     (al_q),
    .tag_out (al_tag)
  );

  // Stage D: numerators, their signs and magnitudes, and a0.
  logic signed [34:0] n [5];
  logic signed [34:0] alpha_s;
  logic signed [34:0] c_ext;

  always_comb begin
    alpha_s = $signed({3'b0, al_q});
    c_ext   = 35'(al_tag.c);
    case (al_tag.ft)
      FT_LP: begin
        n[1] = ONE_Q30 - c_ext;
        n[0] = n[1] >>> 1;
        n[2] = n[0];
      end
      FT_HP: begin
        n[0] = (ONE_Q30 + c_ext) >>> 1;
        n[1] = -(ONE_Q30 + c_ext);
        n[2] = n[0];
      end
      FT_BP: begin
        n[0] = alpha_s;
        n[1] = '0;
        n[2] = -alpha_s;
      end
      FT_BS: begin
        n[0] = ONE_Q30;
        n[1] = -(c_ext <<< 1);
        n[2] = ONE_Q30;
      end
      default: begin
        n[0] = '0;
        n[1] = '0;
        n[2] = '0;
      end
    endcase
    n[3] = -(c_ext <<< 1);
    n[4] = ONE_Q30 - alpha_s;
  end

  logic        d_v;
  logic [1:0]  d_stat;
  logic [31:0] d_a0;
  logic [33:0] d_mag [5];
  logic        d_neg [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= al_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_stat <= al_tag.stat;
      d_a0   <= al_q + 32'h4000_0000;
      for (int k = 0; k < 5; k++) begin
        d_neg[k] <= n[k][34];
        d_mag[k] <= n[k][34] ? 34'(-n[k]) : n[k][33:0];
      end
    end
  end

  // Coefficient dividers: quotient has F+1 fraction bits before rounding.
  logic         e_in_v;
  logic [W-1:0] cq   [5];
  logic [1:0]   cq_stat;
  logic         cq_neg [5];

  bqcd_div #(.NW(CN_W), .DW(32), .QW(W), .SPS(2), .TW(3)) u_coef_div0 (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (d_v),
    .num     ({d_mag[0], {(F+1){1'b0}}}),
    .den     (d_a0),
    .tag_in  ({d_stat, d_neg[0]}),
    .vld_out (e_in_v),
    .quo     (cq[0]),
    .tag_out ({cq_stat, cq_neg[0]})
  );

  for (genvar k = 1; k < 5; k++) begin : g_coef_div
    bqcd_div #(.NW(CN_W), .DW(32), .QW(W), .SPS(2), .TW(1)) u_coef_div (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .vld_in  (d_v),
      .num     ({d_mag[k], {(F+1){1'b0}}}),
      .den     (d_a0),
      .tag_in  (d_neg[k]),
      .vld_out (),
      .quo     (cq[k]),
      .tag_out (cq_neg[k])
    );
  end

  // Stage E: round, saturate, apply sign, zero error words; then the output skid.
  logic [W-1:0] rnd [5];
  logic [W-1:0] fin [5];

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      rnd[k] = W'(({1'b0, cq[k]} + {{W{1'b0}}, 1'b1}) >> 1);
      if (rnd[k] > MAXV) begin
        rnd[k] = MAXV + W'(cq_neg[k]);
      end
      if (cq_stat != ST_OK) begin
        fin[k] = '0;
      end else if (cq_neg[k]) begin
        fin[k] = -rnd[k];
      end else begin
        fin[k] = rnd[k];
      end
    end
  end

  logic         e_v;
  logic [1:0]   e_stat;
  logic [W-1:0] e_coef [5];
  logic         k_v;
  logic [1:0]   k_stat;
  logic [W-1:0] k_coef [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= e_in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_stat <= cq_stat;
      e_coef <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (k_v) begin
      if (rsp.ready) k_v <= 1'b0;
    end else if (e_v && !rsp.ready) begin
      k_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!k_v && e_v && !rsp.ready) begin
      k_stat <= e_stat;
      k_coef <= e_coef;
    end
  end

  assign adv       = !k_v;
  assign req.ready = adv;

  assign rsp.valid   = k_v || e_v;
  assign rsp.status  = k_v ? k_stat : e_stat;
  assign rsp.coef_b0 = k_v ? k_coef[0] : e_coef[0];
  assign rsp.coef_b1 = k_v ? k_coef[1] : e_coef[1];
  assign rsp.coef_b2 = k_v ? k_coef[2] : e_coef[2];
  assign rsp.coef_a1 = k_v ? k_coef[3] : e_coef[3];
  assign rsp.coef_a2 = k_v ? k_coef[4] : e_coef[4];

endmodule
`default_nettype wire

// ----- hdl/bqcd_checker.sv -----
`default_nettype none
module bqcd_checker
  import bqcd_pkg::*;
#(
  parameter int COEF_WIDTH = 32
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  req_ready,
  input wire logic                  rsp_valid,
  input wire logic                  rsp_ready,
  input wire logic [1:0]            status,
  input wire logic [COEF_WIDTH-1:0] coef_b0,
  input wire logic [COEF_WIDTH-1:0] coef_b1,
  input wire logic [COEF_WIDTH-1:0] coef_b2,
  input wire logic [COEF_WIDTH-1:0] coef_a1,
  input wire logic [COEF_WIDTH-1:0] coef_a2
);

  // No word can come out in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("output word valid right after reset");

  // An error word carries all coefficients at zero.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |->
      (coef_b0 == '0 && coef_b1 == '0 && coef_b2 == '0 &&
       coef_a1 == '0 && coef_a2 == '0))
    else $error("error word with nonzero coefficients");

  // The input stalls only while a finished word is waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("input stalled with no output word pending");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("output word dropped while stalled");

endmodule

bind biquad_coefficient_designer bqcd_checker #(.COEF_WIDTH(COEF_WIDTH)) u_bqcd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .coef_b0   (rsp.coef_b0),
  .coef_b1   (rsp.coef_b1),
  .coef_b2   (rsp.coef_b2),
  .coef_a1   (rsp.coef_a1),
  .coef_a2   (rsp.coef_a2)
);
`default_nettype wire
